/* rtl/mctb_pkg.sv */
// ----------------------------------------------------------------------------
// Timer bank package
// Shared constants, operation codes and the command and response word types
// of the multi-channel timer bank.
// ----------------------------------------------------------------------------
package mctb_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int COUNT_BITS_DEF = 32;

    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_ALLOC      = 3'd1;
    localparam logic [2:0] OP_RD_FLAG    = 3'd2;
    localparam logic [2:0] OP_RD_RELOAD  = 3'd3;
    localparam logic [2:0] OP_RD_COUNT   = 3'd4;
    localparam logic [2:0] OP_SET_RELOAD = 3'd5;
    localparam logic [2:0] OP_DISABLE    = 3'd6;
    localparam logic [2:0] OP_ENABLE     = 3'd7;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  timer_select;
        logic [31:0] time_value;
        logic        periodic_mode;
    } cmd_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [3:0]  timer_index;
        logic        expired;
        logic        alloc_error;
    } rsp_t;

    // Control of the timer store: one read and one write per store per cycle.
    typedef struct packed {
        logic rd;
        logic wr_reload;
        logic wr_count;
    } store_ctl_t;

endpackage

/* rtl/multi_channel_timer_bank.sv */
// A tick visits the allocated timers one per cycle, in ascending order, before its response word
// is queued. Read reload and read count, and enable with a zero value, wait for registered store data
// in the read wait step; other command words go straight to the finish step.
// One command word is in progress at a time; the next is taken once the response is queued.
// Reset is asynchronous and active low and clears every timer, flag and the allocation count
// at once through per-entry valid bits: there is no clearing pass.
// ----------------------------------------------------------------------------
// Multi-channel timer bank
// A bank of down-counting one-shot or periodic timers with sticky expiry
// flags, driven by tick, allocate, read, set and enable command words.
// ----------------------------------------------------------------------------
module multi_channel_timer_bank
    import mctb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int USED_W = $clog2(NUM_TIMERS + 1);
    localparam logic [USED_W-1:0]     NUM_LIMIT = USED_W'(NUM_TIMERS);
    localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);

    // The sequencer: IDLE takes a command word, TICK walks the allocated
    // timers, RDWAIT collects registered store data, FINISH queues the
    // response word in the output register.
    typedef enum logic [1:0] {S_IDLE, S_TICK, S_RDWAIT, S_FINISH} state_t;

    state_t                state_reg, state_next;
    logic [USED_W-1:0]     used_reg, used_next;
    logic [NUM_TIMERS-1:0] flags_reg, flags_next;
    logic [NUM_TIMERS-1:0] mode_reg, mode_next;
    logic [USED_W-1:0]     ptr_reg, ptr_next;
    logic                  pv_reg, pv_next;
    logic [IDX_W-1:0]      pidx_reg, pidx_next;
    logic [2:0]            op_reg, op_next;
    logic [IDX_W-1:0]      sel_reg, sel_next;
    rsp_t                  res_reg, res_next;
    rsp_t                  rsp_reg, rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    store_ctl_t            ctl;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    logic [COUNT_BITS-1:0] wr_reload;
    logic [COUNT_BITS-1:0] wr_count;
    logic [COUNT_BITS-1:0] rd_reload;
    logic [COUNT_BITS-1:0] rd_count;

    logic                  accept;
    logic                  sel_ok;
    logic [IDX_W-1:0]      sel_idx;
    logic [COUNT_BITS-1:0] value;
    logic                  live;
    logic                  hit;
    logic [COUNT_BITS-1:0] tick_new;

    mctb_store #(
        .NUM_TIMERS (NUM_TIMERS),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .wr_reload (wr_reload),
        .wr_count  (wr_count),
        .rd_reload (rd_reload),
        .rd_count  (rd_count)
    );

    assign cmd_stall = (state_reg != S_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Selectors beyond the bank are ignored; the cast only narrows values
    // that are already known to be in range.
    assign sel_ok  = int'(cmd.timer_select) < NUM_TIMERS;
    assign sel_idx = IDX_W'(cmd.timer_select);
    assign value   = cmd.time_value[COUNT_BITS-1:0];

    // The shared tick unit: one compare and one decrement per cycle. A timer
    // counts only while its count is nonzero and not above its reload, so a
    // count that was set above the reload leaves the timer frozen. On reaching
    // zero a periodic timer reloads and a one-shot timer stays at zero.
    assign live     = (rd_count != '0) && (rd_count <= rd_reload);
    assign hit      = (rd_count == CNT_ONE);
    assign tick_new = hit ? (mode_reg[pidx_reg] ? rd_reload : '0) : (rd_count - CNT_ONE);

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        flags_next     = flags_reg;
        mode_next      = mode_reg;
        ptr_next       = ptr_reg;
        pv_next        = 1'b0;
        pidx_next      = pidx_reg;
        op_next        = op_reg;
        sel_next       = sel_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        ctl            = '0;
        rd_addr        = '0;
        wr_addr        = '0;
        wr_reload      = '0;
        wr_count       = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next   = '0;
                    op_next    = cmd.operation;
                    sel_next   = sel_idx;
                    state_next = S_FINISH;
                    if (cmd.operation == OP_TICK)
                    begin
                        ptr_next   = '0;
                        state_next = S_TICK;
                    end
                    else if (cmd.operation == OP_ALLOC)
                    begin
                        if (used_reg >= NUM_LIMIT)
                        begin
                            res_next.alloc_error = 1'b1;
                        end
                        else
                        begin
                            // The new timer starts clean: flag cleared, then
                            // reload and count both take the period.
                            ctl.wr_reload                  = 1'b1;
                            ctl.wr_count                   = 1'b1;
                            wr_addr                        = IDX_W'(used_reg);
                            wr_reload                      = value;
                            wr_count                       = value;
                            mode_next[IDX_W'(used_reg)]    = cmd.periodic_mode;
                            flags_next[IDX_W'(used_reg)]   = 1'b0;
                            used_next                      = used_reg + 1'b1;
                            res_next.timer_index           = 4'(used_reg);
                        end
                    end
                    else if (sel_ok)
                    begin
                        unique case (cmd.operation)
                            OP_RD_FLAG:
                            begin
                                res_next.read_data  = 32'(flags_reg[sel_idx]);
                                flags_next[sel_idx] = 1'b0;
                            end
                            OP_RD_RELOAD, OP_RD_COUNT:
                            begin
                                ctl.rd     = 1'b1;
                                rd_addr    = sel_idx;
                                state_next = S_RDWAIT;
                            end
                            OP_SET_RELOAD:
                            begin
                                // A new reload also stops the timer.
                                ctl.wr_reload = 1'b1;
                                ctl.wr_count  = 1'b1;
                                wr_addr       = sel_idx;
                                wr_reload     = value;
                            end
                            OP_DISABLE:
                            begin
                                ctl.wr_count = 1'b1;
                                wr_addr      = sel_idx;
                            end
                            OP_ENABLE:
                            begin
                                if (value != '0)
                                begin
                                    ctl.wr_count = 1'b1;
                                    wr_addr      = sel_idx;
                                    wr_count     = value;
                                end
                                else
                                begin
                                    // Restart from the reload value, which
                                    // has to be fetched first.
                                    ctl.rd     = 1'b1;
                                    rd_addr    = sel_idx;
                                    state_next = S_RDWAIT;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end

            S_TICK:
            begin
                // Reads run one timer ahead of the write-back, so the read
                // and write addresses never meet.
                if (ptr_reg < used_reg)
                begin
                    ctl.rd    = 1'b1;
                    rd_addr   = IDX_W'(ptr_reg);
                    pv_next   = 1'b1;
                    pidx_next = IDX_W'(ptr_reg);
                    ptr_next  = ptr_reg + 1'b1;
                end
                if (pv_reg && live)
                begin
                    ctl.wr_count = 1'b1;
                    wr_addr      = pidx_reg;
                    wr_count     = tick_new;
                    if (hit)
                    begin
                        // Ascending order, so the last hit is the highest.
                        flags_next[pidx_reg] = 1'b1;
                        res_next.expired     = 1'b1;
                        res_next.timer_index = 4'(pidx_reg);
                    end
                end
                if (!pv_reg && (ptr_reg >= used_reg))
                begin
                    state_next = S_FINISH;
                end
            end

            S_RDWAIT:
            begin
                unique case (op_reg)
                    OP_RD_RELOAD:
                    begin
                        res_next.read_data = 32'(rd_reload);
                    end
                    OP_RD_COUNT:
                    begin
                        res_next.read_data = 32'(rd_count);
                    end
                    default:
                    begin
                        ctl.wr_count = 1'b1;
                        wr_addr      = sel_reg;
                        wr_count     = rd_reload;
                    end
                endcase
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            flags_reg     <= '0;
            mode_reg      <= '0;
            ptr_reg       <= '0;
            pv_reg        <= 1'b0;
            pidx_reg      <= '0;
            op_reg        <= OP_TICK;
            sel_reg       <= '0;
            res_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            flags_reg     <= flags_next;
            mode_reg      <= mode_next;
            ptr_reg       <= ptr_next;
            pv_reg        <= pv_next;
            pidx_reg      <= pidx_next;
            op_reg        <= op_next;
            sel_reg       <= sel_next;
            res_reg       <= res_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= NUM_LIMIT)
        else $error("allocation count beyond the bank size");

    a_tick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> (state_reg == S_TICK) && (USED_W'(pidx_reg) < used_reg))
        else $error("tick visits a timer that is not allocated");

    a_alloc_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.operation == OP_ALLOC) && (used_reg < NUM_LIMIT))
        |=> used_reg == $past(used_reg) + 1'b1)
        else $error("successful allocation did not advance the count");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("response word raised outside the finish step");

    a_reload_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_reload |-> (state_reg == S_IDLE) && accept)
        else $error("reload written without a command word");
`endif

endmodule

/* rtl/mctb_store.sv */
// ----------------------------------------------------------------------------
// Timer store
// Reload and count memories with one shared read address, registered read
// data and per-entry valid bits so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module mctb_store
    import mctb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  store_ctl_t                                            ctl,
    input  logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] rd_addr,
    input  logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] wr_addr,
    input  logic [COUNT_BITS-1:0]                                 wr_reload,
    input  logic [COUNT_BITS-1:0]                                 wr_count,
    output logic [COUNT_BITS-1:0]                                 rd_reload,
    output logic [COUNT_BITS-1:0]                                 rd_count
);

    logic [COUNT_BITS-1:0] reload_mem [NUM_TIMERS];
    logic [COUNT_BITS-1:0] count_mem  [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] rl_vld_reg;
    logic [NUM_TIMERS-1:0] ct_vld_reg;
    logic [COUNT_BITS-1:0] rd_rl_reg;
    logic [COUNT_BITS-1:0] rd_ct_reg;
    logic                  rd_rl_vld_reg;
    logic                  rd_ct_vld_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_reload)
        begin
            reload_mem[wr_addr] <= wr_reload;
        end
        if (ctl.wr_count)
        begin
            count_mem[wr_addr] <= wr_count;
        end
        if (ctl.rd)
        begin
            rd_rl_reg <= reload_mem[rd_addr];
            rd_ct_reg <= count_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rl_vld_reg    <= '0;
            ct_vld_reg    <= '0;
            rd_rl_vld_reg <= 1'b0;
            rd_ct_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_reload)
            begin
                rl_vld_reg[wr_addr] <= 1'b1;
            end
            if (ctl.wr_count)
            begin
                ct_vld_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd)
            begin
                rd_rl_vld_reg <= rl_vld_reg[rd_addr];
                rd_ct_vld_reg <= ct_vld_reg[rd_addr];
            end
        end
    end

    // An entry never written since reset reads as zero.
    assign rd_reload = rd_rl_vld_reg ? rd_rl_reg : '0;
    assign rd_count  = rd_ct_vld_reg ? rd_ct_reg : '0;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timer bank testbench
// Drives command words into the multi-channel timer bank and checks each
// response word against a cycle-free model of the timers kept in the bench.
// A short directed part covers the corner cases and is followed by random
// traffic with random idling on both sides and one long response hold-off.
// ----------------------------------------------------------------------------
module tb;

    import mctb_pkg::*;

    localparam int NUM          = NUM_TIMERS_DEF;
    localparam int CBITS        = COUNT_BITS_DEF;
    localparam int HOLD_CYCLES  = 150;
    localparam int SETTLE       = 40;
    localparam int RANDOM_WORDS = 500;
    localparam int CHUNK        = 50;

    // Clock and reset. Every input of the block has a known value from time zero.
    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    multi_channel_timer_bank #(
        .NUM_TIMERS (NUM),
        .COUNT_BITS (CBITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // ------------------------------------------------------------------------
    // Model of the timer bank. It is updated when a command word is accepted,
    // which is safe because the block works on one word at a time and answers
    // in order.
    // ------------------------------------------------------------------------
    logic [CBITS-1:0] reload_q [NUM];
    logic [CBITS-1:0] count_q  [NUM];
    logic             periodic_q [NUM];
    logic [NUM-1:0]   expiry_q;
    logic [4:0]       used_q;

    // Response words still owed by the block, oldest first.
    rsp_t awaited_rsp [$];

    // Idling controls shared by the sender, the receiver and the tests.
    bit          send_idle    = 1'b1;
    bit          recv_idle    = 1'b1;
    bit          hold_off_req = 1'b0;
    int unsigned stall_left   = 0;

    // Run statistics, used for the summary only.
    int fault_count   = 0;
    int words_sent    = 0;
    int ticks_sent    = 0;
    int allocs_sent   = 0;
    int rsp_checked   = 0;
    int expiries_seen = 0;
    int refusals_seen = 0;

    initial
    begin
        for (int i = 0; i < NUM; i++)
        begin
            reload_q[i]   = '0;
            count_q[i]    = '0;
            periodic_q[i] = 1'b0;
        end
        expiry_q = '0;
        used_q   = '0;
    end

    // Applies one command word to the model and returns the response that
    // the block must give for it.
    function automatic rsp_t bank_response(input cmd_t word);
        rsp_t             r;
        logic [CBITS-1:0] v;
        logic [CBITS-1:0] c;
        int               sel;
        r   = '0;
        v   = word.time_value[CBITS-1:0];
        sel = word.timer_select;
        if (word.operation == OP_TICK)
        begin
            // Only allocated timers take part. A count above its reload is frozen;
            // a count equal to the reload always moves, even at the largest value.
            for (int i = 0; i < NUM && i < used_q; i++)
            begin
                c = count_q[i];
                if (c != '0 && c <= reload_q[i])
                begin
                    c = c - 1'b1;
                    if (c == '0)
                    begin
                        r.expired     = 1'b1;
                        r.timer_index = 4'(i);
                        expiry_q[i]   = 1'b1;
                        if (periodic_q[i])
                            c = reload_q[i];
                    end
                    count_q[i] = c;
                end
            end
        end
        else if (word.operation == OP_ALLOC)
        begin
            if (used_q >= NUM)
                r.alloc_error = 1'b1;
            else
            begin
                // The new timer is wiped, its flag included, and then loaded.
                expiry_q[used_q]   = 1'b0;
                reload_q[used_q]   = v;
                count_q[used_q]    = v;
                periodic_q[used_q] = word.periodic_mode;
                r.timer_index      = 4'(used_q);
                used_q             = used_q + 1'b1;
            end
        end
        else if (sel < NUM)
        begin
            // Addressed operations work on the store whether or not the timer
            // has been handed out yet.
            case (word.operation)
                OP_RD_FLAG:
                begin
                    if (expiry_q[sel])
                    begin
                        expiry_q[sel] = 1'b0;
                        r.read_data   = 32'd1;
                    end
                end
                OP_RD_RELOAD:  r.read_data = 32'(reload_q[sel]);
                OP_RD_COUNT:   r.read_data = 32'(count_q[sel]);
                OP_SET_RELOAD:
                begin
                    reload_q[sel] = v;
                    count_q[sel]  = '0;
                end
                OP_DISABLE:    count_q[sel] = '0;
                OP_ENABLE:     count_q[sel] = (v != '0) ? v : reload_q[sel];
                default:       ;
            endcase
        end
        return r;
    endfunction

    // Length of an idle stretch: usually none, mostly short, now and then long.
    function automatic int unsigned pick_gap(input int unsigned pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one command word and records the response it must cause. The
    // valid stays high into the next word when no gap is drawn, so that it is
    // never lowered and raised within one time step.
    task automatic send_word(input logic [2:0] op, input logic [3:0] sel,
                             input logic [31:0] value, input logic periodic);
        cmd_t        word;
        int unsigned gap;
        word.operation     = op;
        word.timer_select  = sel;
        word.time_value    = value;
        word.periodic_mode = periodic;
        cmd       <= word;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        awaited_rsp.push_back(bank_response(word));
        words_sent++;
        if (op == OP_TICK)
            ticks_sent++;
        if (op == OP_ALLOC)
            allocs_sent++;
        gap = send_idle ? pick_gap(40) : 0;
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver. It stalls at random, and on request holds off for a long
    // stretch that it counts out itself, so that the block backs up.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_off_req)
        begin
            hold_off_req = 1'b0;
            stall_left   = HOLD_CYCLES;
        end
        else if (stall_left == 0 && recv_idle)
            stall_left = pick_gap(30);
        if (stall_left != 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else
            rsp_stall <= 1'b0;
    end

    task automatic note_fault(input string what, input logic [31:0] want,
                              input logic [31:0] got);
        fault_count++;
        if (fault_count <= 10)
            $display("tb: mismatch in %s at %0t ns: expected %h, got %h",
                     what, $time, want, got);
    endtask

    // Every accepted response word is checked against the oldest expectation.
    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (awaited_rsp.size() == 0)
                note_fault("unexpected response word", 32'd0, rsp.read_data);
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp.read_data !== want.read_data)
                    note_fault("read_data", want.read_data, rsp.read_data);
                if (rsp.timer_index !== want.timer_index)
                    note_fault("timer_index", 32'(want.timer_index), 32'(rsp.timer_index));
                if (rsp.expired !== want.expired)
                    note_fault("expired", 32'(want.expired), 32'(rsp.expired));
                if (rsp.alloc_error !== want.alloc_error)
                    note_fault("alloc_error", 32'(want.alloc_error), 32'(rsp.alloc_error));
                rsp_checked++;
                if (want.expired)
                    expiries_seen++;
                if (want.alloc_error)
                    refusals_seen++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Before anything is allocated a tick finds nothing to do, yet the stores
    // of a timer can still be written and read. Enable with a zero value takes
    // the reload, here the largest one.
    task automatic test_unallocated_store();
        send_word(OP_TICK,       4'd0,  32'd0,        1'b0);
        send_word(OP_RD_COUNT,   4'd15, 32'd0,        1'b0);
        send_word(OP_SET_RELOAD, 4'd15, 32'hFFFFFFFF, 1'b1);
        send_word(OP_RD_RELOAD,  4'd15, 32'd0,        1'b0);
        send_word(OP_ENABLE,     4'd15, 32'd0,        1'b0);
        send_word(OP_RD_COUNT,   4'd15, 32'd0,        1'b0);
    endtask

    // A periodic timer, a one-shot at the largest period and a one-shot that
    // runs out on the first tick. Flags are sticky until read, and a read
    // clears them.
    task automatic test_countdown();
        send_word(OP_ALLOC,   4'd0, 32'd3,        1'b1);
        send_word(OP_ALLOC,   4'd0, 32'hFFFFFFFF, 1'b0);
        send_word(OP_ALLOC,   4'd0, 32'd1,        1'b0);
        repeat (3)
            send_word(OP_TICK, 4'd0, 32'd0, 1'b0);
        send_word(OP_RD_COUNT, 4'd1, 32'd0, 1'b0);
        send_word(OP_RD_FLAG,  4'd0, 32'd0, 1'b0);
        send_word(OP_RD_FLAG,  4'd0, 32'd0, 1'b0);
        send_word(OP_RD_FLAG,  4'd2, 32'd0, 1'b0);
    endtask

    // Set reload stops a timer; a count loaded above the reload stays frozen.
    // Disable clears the count and enable with zero restarts from the reload.
    task automatic test_frozen_and_disable();
        send_word(OP_SET_RELOAD, 4'd1, 32'd5, 1'b0);
        send_word(OP_ENABLE,     4'd1, 32'd9, 1'b0);
        send_word(OP_TICK,       4'd0, 32'd0, 1'b0);
        send_word(OP_RD_COUNT,   4'd1, 32'd0, 1'b0);
        send_word(OP_DISABLE,    4'd0, 32'd0, 1'b0);
        send_word(OP_TICK,       4'd0, 32'd0, 1'b0);
        send_word(OP_ENABLE,     4'd0, 32'd0, 1'b0);
        send_word(OP_RD_COUNT,   4'd0, 32'd0, 1'b0);
    endtask

    // Mostly addresses timers already handed out, now and then any timer.
    function automatic logic [3:0] pick_timer();
        if (used_q != 0 && $urandom_range(0, 9) < 8)
            return 4'($urandom_range(0, used_q - 1));
        return 4'($urandom_range(0, 15));
    endfunction

    // Small periods are favoured so that timers actually run out between
    // the reads, with zero, the largest value and wide random values mixed in.
    function automatic logic [31:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 8);
        if (r < 70)
            return 32'd0;
        if (r < 80)
            return $urandom_range(9, 40);
        if (r < 92)
            return $urandom;
        return 32'hFFFFFFFF;
    endfunction

    task automatic send_random_word();
        int unsigned r;
        logic [2:0]  op;
        r = $urandom_range(0, 99);
        if (r < 40)
            op = OP_TICK;
        else if (r < 48)
            op = OP_ALLOC;
        else if (r < 58)
            op = OP_RD_FLAG;
        else if (r < 64)
            op = OP_RD_RELOAD;
        else if (r < 72)
            op = OP_RD_COUNT;
        else if (r < 78)
            op = OP_SET_RELOAD;
        else if (r < 84)
            op = OP_DISABLE;
        else
            op = OP_ENABLE;
        send_word(op, pick_timer(), pick_value(), 1'($urandom_range(0, 1)));
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering words back to back, so the block fills and stalls its input.
    task automatic test_back_pressure();
        send_idle    = 1'b0;
        hold_off_req = 1'b1;
        repeat (24)
            send_random_word();
        send_idle = 1'b1;
    endtask

    // Random traffic in chunks; each chunk draws its own idling, and about one
    // chunk in four runs with no idling on either side.
    task automatic test_random_traffic();
        int unsigned mode;
        for (int n = 0; n < RANDOM_WORDS; n += CHUNK)
        begin
            mode      = $urandom_range(0, 3);
            send_idle = (mode != 0);
            recv_idle = (mode != 0);
            repeat (CHUNK)
                send_random_word();
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unallocated_store();
        test_countdown();
        test_frozen_and_disable();
        test_back_pressure();
        test_random_traffic();

        cmd_valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        // A tick with every timer in use is the slowest word; wait that long
        // and more so that any stray response word is still caught.
        repeat (SETTLE) @(posedge clk);

        $display("tb: %0d command words sent (%0d ticks, %0d allocations), %0d responses checked",
                 words_sent, ticks_sent, allocs_sent, rsp_checked);
        $display("tb: %0d ticks with an expiry, %0d refused allocations, %0d mismatches",
                 expiries_seen, refusals_seen, fault_count);
        if (fault_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Guard against a hang: far longer than the slowest correct run needs.
    initial
    begin
        #5000000;
        $display("tb: timeout with %0d response words outstanding", awaited_rsp.size());
        $display("tb: errors");
        $finish;
    end

endmodule
